@@ rtl/lrp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrp_pkg - shared types and helpers for the relocation patcher
// Relocation type codes, status codes, record/result structs and the
// instruction field insert functions.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int unsigned AddrW    = 64;
  localparam int unsigned WordW    = 32;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 64;
  localparam logic [AddrW-1:0] PltBaseRst = '0;

  // ELF relocation type numbers
  localparam logic [TypeW-1:0] RtB26         = 8'd66;
  localparam logic [TypeW-1:0] RtPcalaHi20   = 8'd71;
  localparam logic [TypeW-1:0] RtPcalaLo12   = 8'd72;
  localparam logic [TypeW-1:0] RtPcala64Lo20 = 8'd73;
  localparam logic [TypeW-1:0] RtPcala64Hi12 = 8'd74;
  localparam logic [TypeW-1:0] RtGotHi20     = 8'd75;
  localparam logic [TypeW-1:0] RtGotLo12     = 8'd76;
  localparam logic [TypeW-1:0] RtGot64Lo20   = 8'd77;
  localparam logic [TypeW-1:0] RtGot64Hi12   = 8'd78;
  localparam logic [TypeW-1:0] RtCall36      = 8'd110;

  // register byte addresses (8-byte spacing)
  localparam logic [PaddrW-1:0] RegPltBase = 4'h0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_OFFSET = 3'd1,
    ST_PLT_ADDEND = 3'd2,
    ST_RANGE      = 3'd3,
    ST_MISALIGN   = 3'd4,
    ST_UNKNOWN    = 3'd5
  } status_e;

  typedef struct packed {
    logic [TypeW-1:0] rtype;
    logic [AddrW-1:0] section_base;
    logic [SizeW-1:0] section_size;
    logic [AddrW-1:0] place_off;
    logic [AddrW-1:0] addend;
    logic [AddrW-1:0] sym_addr;
    logic [31:0]      sym_idx;
    logic [WordW-1:0] insn_word0;
    logic [WordW-1:0] insn_word1;
  } record_t;

  typedef struct packed {
    logic [WordW-1:0] patched_word0;
    logic [WordW-1:0] patched_word1;
    logic [1:0]       words_written;
    status_e          status;
  } result_t;

  function automatic logic [WordW-1:0] put_j20(logic [WordW-1:0] w, logic [19:0] imm);
    return (w & 32'hfe00001f) | {7'd0, imm, 5'd0};
  endfunction

  function automatic logic [WordW-1:0] put_k12(logic [WordW-1:0] w, logic [11:0] imm);
    return (w & 32'hffc003ff) | {10'd0, imm, 10'd0};
  endfunction

  function automatic logic [WordW-1:0] put_k16(logic [WordW-1:0] w, logic [15:0] imm);
    return (w & 32'hfc0003ff) | {6'd0, imm, 10'd0};
  endfunction

  function automatic logic [WordW-1:0] put_d10k16(logic [WordW-1:0] w, logic [25:0] imm);
    return (w & 32'hfc000000) | {6'd0, imm[15:0], imm[25:16]};
  endfunction

endpackage

@@ rtl/loongarch_relocation_patcher.sv @@
// ----------------------------------------------------------------------------
// loongarch_relocation_patcher - LoongArch ELF relocation patcher
// Streams relocation records in and patched instruction words out.
// ----------------------------------------------------------------------------
// One relocation record per transfer on the slave stream, one result per
// record on the master stream, in order. A record is captured in an input
// register, evaluated by a single combinational pass (place/target adds,
// PLT slot, range and alignment checks, field insertion) and lands in the
// output register. Throughput is 1 record per cycle without backpressure;
// each of the two pipeline registers frees once its successor takes its
// contents. Backpressure on the master side stalls both stages.
// Record tuser carries the relocation type; result tdata carries the patched
// words, the number of words to write back (0 on error) and the status code.
// The PLT base register sits at APB byte address 0 and must only be
// rewritten while no records are in flight.
// ----------------------------------------------------------------------------
module loongarch_relocation_patcher #(
  parameter logic [lrp_pkg::AddrW-1:0] PltBaseReset = lrp_pkg::PltBaseRst
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrp_pkg::PaddrW-1:0]  paddr,
  input  logic [lrp_pkg::PdataW-1:0]  pwdata,
  output logic [lrp_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  // record stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata, from bit 0: section_base[63:0], section_size[95:64],
  // place_off[159:96], addend[223:160], sym_addr[287:224],
  // sym_idx[319:288], insn_word0[351:320], insn_word1[383:352]
  input  logic [383:0]                s_axis_tdata,
  // tuser: rtype[7:0]
  input  logic [7:0]                  s_axis_tuser,
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata, from bit 0: patched_word0[31:0], patched_word1[63:32],
  // words_written[65:64], status[68:66], zero[71:69]
  output logic [71:0]                 m_axis_tdata
);
  import lrp_pkg::*;

  logic [AddrW-1:0] plt_base;
  record_t          rec_d, rec_q;
  result_t          res_d, res_q;
  logic             in_vld_q, out_vld_q;
  logic             out_adv, s_xfer;

  lrp_apb_regs #(
    .PltBaseReset(PltBaseReset)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .plt_base_o(plt_base)
  );

  // unpack the incoming record
  always_comb begin
    rec_d.rtype        = s_axis_tuser;
    rec_d.section_base = s_axis_tdata[63:0];
    rec_d.section_size = s_axis_tdata[95:64];
    rec_d.place_off    = s_axis_tdata[159:96];
    rec_d.addend       = s_axis_tdata[223:160];
    rec_d.sym_addr     = s_axis_tdata[287:224];
    rec_d.sym_idx      = s_axis_tdata[319:288];
    rec_d.insn_word0   = s_axis_tdata[351:320];
    rec_d.insn_word1   = s_axis_tdata[383:352];
  end

  // output register frees when empty or being drained this cycle;
  // input register frees when its record moves on
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  lrp_patch u_patch (
    .rec_i     (rec_q),
    .plt_base_i(plt_base),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        in_vld_q <= 1'b1;
      end else if (out_adv) begin
        in_vld_q <= 1'b0;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      rec_q <= rec_d;
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'd0, res_q.status, res_q.words_written,
                          res_q.patched_word1, res_q.patched_word0};

`ifndef SYNTHESIS
  // a result is written back exactly when the status is clean
  a_words_vs_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((res_q.status == ST_OK) == (res_q.words_written != 2'd0)))
    else $error("words_written disagrees with status");

  // two words only come from a successful call36
  a_two_words_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.words_written == 2'd2) |-> (res_q.status == ST_OK))
    else $error("two-word writeback with error status");

  // a stalled result is never dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q)
    else $error("stalled result lost");

  // a captured record waits while the output register is blocked
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_adv) |=> (in_vld_q && $stable(rec_q)))
    else $error("input record lost under backpressure");
`endif

endmodule

@@ rtl/lrp_apb_regs.sv @@
// ----------------------------------------------------------------------------
// lrp_apb_regs - configuration register file
// Holds the PLT base address, written and read over APB.
// ----------------------------------------------------------------------------
module lrp_apb_regs #(
  parameter logic [lrp_pkg::AddrW-1:0] PltBaseReset = lrp_pkg::PltBaseRst
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrp_pkg::PaddrW-1:0]   paddr,
  input  logic [lrp_pkg::PdataW-1:0]   pwdata,
  output logic [lrp_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  output logic [lrp_pkg::AddrW-1:0]    plt_base_o
);
  import lrp_pkg::*;

  logic [AddrW-1:0] plt_base_q;
  logic             hit_plt;

  // decode on the 8-byte register slot only
  assign hit_plt = (paddr[PaddrW-1:3] == RegPltBase[PaddrW-1:3]);
  assign pready  = 1'b1;
  assign prdata  = hit_plt ? plt_base_q : '0;
  assign plt_base_o = plt_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plt_base_q <= PltBaseReset;
    end else if (psel && penable && pwrite && pready && hit_plt) begin
      plt_base_q <= pwdata;
    end
  end

endmodule

@@ rtl/lrp_patch.sv @@
// ----------------------------------------------------------------------------
// lrp_patch - relocation evaluate and patch datapath
// Combinational: address math, range/alignment checks, field insertion.
// ----------------------------------------------------------------------------
module lrp_patch (
  input  lrp_pkg::record_t              rec_i,
  input  logic [lrp_pkg::AddrW-1:0]     plt_base_i,
  output lrp_pkg::result_t              res_o
);
  import lrp_pkg::*;

  logic [AddrW-1:0] place, dest, slot, target, disp, disp_adj;
  logic [AddrW-1:0] at, pdelta;
  logic [36:0]      slot_off;
  logic [SizeW+1:0] end_off;
  logic [3:0]       need;
  logic             known, is_call, is_branch, use_plt, addend_pos;
  logic             off_ok, b26_ok, c36_ok;
  logic [WordW-1:0] r0, r1;
  logic [1:0]       nw;
  status_e          st;

  assign is_call   = (rec_i.rtype == RtCall36);
  assign is_branch = is_call || (rec_i.rtype == RtB26);
  assign known     = is_branch || (rec_i.rtype inside {[RtPcalaHi20:RtGot64Hi12]});

  // place must lie fully inside the section
  assign need    = is_call ? 4'd8 : 4'd4;
  assign end_off = {2'b00, rec_i.place_off[SizeW-1:0]} + {{(SizeW-2){1'b0}}, need};
  assign off_ok  = (rec_i.place_off[AddrW-1:SizeW] == '0) &&
                   (end_off <= {2'b00, rec_i.section_size});

  assign place = rec_i.section_base + rec_i.place_off;
  assign dest  = rec_i.sym_addr + rec_i.addend;

  // PLT slot: plt_base + 24 * index
  assign use_plt    = !rec_i.sym_idx[31];
  assign addend_pos = !rec_i.addend[AddrW-1] && (rec_i.addend != '0);
  assign slot_off   = {1'b0, rec_i.sym_idx, 4'd0} + {2'b00, rec_i.sym_idx, 3'd0};
  assign slot       = plt_base_i + {27'd0, slot_off};
  assign target     = use_plt ? slot : rec_i.sym_addr;
  assign disp       = target + rec_i.addend - place;
  assign disp_adj   = disp + 64'h20000;

  // B26: -2^27 .. 2^27-4
  assign b26_ok = ((disp[63:27] == '0) && (disp[26:0] <= 27'h7fffffc)) ||
                  (disp[63:27] == '1);
  // CALL36: disp + 0x20000 in -2^37 .. 2^37-4
  assign c36_ok = ((disp_adj[63:37] == '0) && (disp_adj[36:0] <= 37'h1ffffffffc)) ||
                  (disp_adj[63:37] == '1);

  // page delta; 64-bit pairs use the pc of the leading pcalau12i
  always_comb begin
    at = place;
    if (rec_i.rtype == RtPcala64Lo20 || rec_i.rtype == RtGot64Lo20) begin
      at = place - 64'd8;
    end else if (rec_i.rtype == RtPcala64Hi12 || rec_i.rtype == RtGot64Hi12) begin
      at = place - 64'd12;
    end
    pdelta = {dest[63:12], 12'd0} - {at[63:12], 12'd0};
    if (dest[11]) begin
      pdelta = pdelta + 64'd4096 - 64'h100000000;
    end
    if (pdelta[31]) begin
      pdelta = pdelta + 64'h100000000;
    end
  end

  always_comb begin
    r0 = rec_i.insn_word0;
    r1 = rec_i.insn_word1;
    nw = 2'd1;
    st = ST_OK;
    if (!known) begin
      st = ST_UNKNOWN;
    end else if (!off_ok) begin
      st = ST_BAD_OFFSET;
    end else if (is_branch) begin
      if (use_plt && addend_pos) begin
        st = ST_PLT_ADDEND;
      end else if (is_call ? !c36_ok : !b26_ok) begin
        st = ST_RANGE;
      end else if (disp[1:0] != 2'b00) begin
        st = ST_MISALIGN;
      end else if (is_call) begin
        r0 = put_j20(rec_i.insn_word0, disp_adj[37:18]);
        r1 = put_k16(rec_i.insn_word1, disp[17:2]);
        nw = 2'd2;
      end else begin
        r0 = put_d10k16(rec_i.insn_word0, disp[27:2]);
      end
    end else begin
      case (rec_i.rtype)
        RtPcalaHi20, RtGotHi20:     r0 = put_j20(rec_i.insn_word0, pdelta[31:12]);
        RtPcalaLo12, RtGotLo12:     r0 = put_k12(rec_i.insn_word0, dest[11:0]);
        RtPcala64Lo20, RtGot64Lo20: r0 = put_j20(rec_i.insn_word0, pdelta[51:32]);
        default:                    r0 = put_k12(rec_i.insn_word0, pdelta[63:52]);
      endcase
    end
    if (st != ST_OK) begin
      r0 = rec_i.insn_word0;
      r1 = rec_i.insn_word1;
      nw = 2'd0;
    end
  end

  assign res_o.patched_word0 = r0;
  assign res_o.patched_word1 = r1;
  assign res_o.words_written = nw;
  assign res_o.status        = st;

endmodule
